// ----- rtl/pipc_pkg.sv -----
// Shared types, codes and helpers for the point-in-polygon classifier.
// No dependencies; used by pipc_edge_term and point_in_polygon_classifier_unit.
package pipc_pkg;

  // Width of the coordinate fields on the ports.
  localparam int CoordFieldW = 32;
  // Default number of coordinate bits used, sign-extended.
  localparam int CoordWidth  = 32;

  typedef enum logic {
    OP_QUERY  = 1'b0,
    OP_VERTEX = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    POS_EXTERIOR = 2'd0,
    POS_INTERIOR = 2'd1,
    POS_ON_EDGE  = 2'd2,
    POS_VERTEX   = 2'd3
  } position_e;

  // Per-edge straddle and denominator sign flags.
  typedef struct packed {
    logic rs;       // edge straddles the line above/not-above the point
    logic ls;       // edge straddles the line below/not-below the point
    logic den_pos;  // y of previous vertex above y of current vertex
  } edge_flags_t;

  typedef struct packed {
    logic right;
    logic left;
  } edge_toggle_t;

  // Crossing side from the sign of the cross product (gt / eq of the two
  // products) against the denominator sign.
  function automatic edge_toggle_t edge_toggle(edge_flags_t flags, logic gt, logic eq);
    edge_toggle_t t;
    t.right = flags.rs && !eq && (gt == flags.den_pos);
    t.left  = flags.ls && !eq && (gt != flags.den_pos);
    return t;
  endfunction

  function automatic position_e classify(logic hit, logic right, logic left);
    position_e p;
    if (hit) begin
      p = POS_VERTEX;
    end else if (right != left) begin
      p = POS_ON_EDGE;
    end else if (right) begin
      p = POS_INTERIOR;
    end else begin
      p = POS_EXTERIOR;
    end
    return p;
  endfunction

endpackage

// ----- rtl/point_in_polygon_classifier_unit.sv -----
// Top level of the point-in-polygon classifier (two-ray crossing test).
// Uses pipc_pkg and pipc_edge_term.
//
// A query request (op 0) sets the point; vertex requests (op 1) follow, and
// the one flagged last yields one position: 0 exterior, 1 interior, 2 on an
// edge, 3 the point is a vertex. One request is taken every cycle while
// in_stall_o is low. A result moves from the request register, holding the
// vertex offsets from the point, to the next stage, holding the cross
// products of the open and closing edges, and on to the output stage, which
// compares them and updates the crossing parities. in_stall_o rises only
// while a finished result is held by out_stall_i, the middle stage holds
// another last vertex and the request register is occupied; requests that
// produce no result keep flowing past a waiting result.
module point_in_polygon_classifier_unit #(
  parameter int COORD_WIDTH = pipc_pkg::CoordWidth
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             op_i,
  input  logic [pipc_pkg::CoordFieldW-1:0] coord_x_i,
  input  logic [pipc_pkg::CoordFieldW-1:0] coord_y_i,
  input  logic                             last_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [1:0]                       position_o
);

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;

  // handshake
  logic in_accept, a_move, b_fire, b_result;

  // point and polygon tracking at the input side
  logic [COORD_WIDTH-1:0] query_x_q, query_y_q;
  logic signed [DW-1:0]   first_x_q, first_y_q, prev_x_q, prev_y_q;
  logic                   have_first_q;
  logic signed [DW-1:0]   cur_x, cur_y, first_x_sel, first_y_sel;
  logic [COORD_WIDTH-1:0] cx, cy;

  // stage A
  logic                 a_valid_q, a_query_q, a_last_q, a_edge_q, a_hit_q;
  logic signed [DW-1:0] a_cur_x_q, a_cur_y_q, a_prev_x_q, a_prev_y_q;
  logic signed [DW-1:0] a_first_x_q, a_first_y_q;

  // stage B
  logic                  b_valid_q, b_query_q, b_last_q, b_edge_q, b_hit_q;
  pipc_pkg::edge_flags_t open_flags, close_flags, b_open_flags_q, b_close_flags_q;
  logic signed [PW-1:0]  open_pa, open_pb, close_pa, close_pb;
  logic signed [PW-1:0]  b_open_pa_q, b_open_pb_q, b_close_pa_q, b_close_pb_q;

  // crossing state and result
  logic                   right_q, left_q, hit_q;
  logic                   right_n, left_n, hit_n;
  pipc_pkg::edge_toggle_t open_tg, close_tg;
  logic                   out_valid_q;
  logic [1:0]             pos_q;

  assign b_result   = b_valid_q && !b_query_q && b_last_q;
  assign b_fire     = b_valid_q && !(b_result && out_valid_q && out_stall_i);
  assign a_move     = a_valid_q && (!b_valid_q || b_fire);
  assign in_stall_o = a_valid_q && !a_move;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign cx    = coord_x_i[COORD_WIDTH-1:0];
  assign cy    = coord_y_i[COORD_WIDTH-1:0];
  assign cur_x = $signed({cx[COORD_WIDTH-1], cx}) -
                 $signed({query_x_q[COORD_WIDTH-1], query_x_q});
  assign cur_y = $signed({cy[COORD_WIDTH-1], cy}) -
                 $signed({query_y_q[COORD_WIDTH-1], query_y_q});
  assign first_x_sel = have_first_q ? first_x_q : cur_x;
  assign first_y_sel = have_first_q ? first_y_q : cur_y;

  // input side: point, first and previous vertex
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      query_x_q    <= '0;
      query_y_q    <= '0;
      first_x_q    <= '0;
      first_y_q    <= '0;
      prev_x_q     <= '0;
      prev_y_q     <= '0;
      have_first_q <= 1'b0;
    end else if (in_accept) begin
      if (op_i == pipc_pkg::OP_QUERY) begin
        query_x_q    <= cx;
        query_y_q    <= cy;
        have_first_q <= 1'b0;
      end else begin
        first_x_q    <= first_x_sel;
        first_y_q    <= first_y_sel;
        prev_x_q     <= cur_x;
        prev_y_q     <= cur_y;
        have_first_q <= !last_i;
      end
    end
  end

  // stage A control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_accept) begin
      a_valid_q <= 1'b1;
    end else if (a_move) begin
      a_valid_q <= 1'b0;
    end
  end

  // stage A payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      a_query_q   <= (op_i == pipc_pkg::OP_QUERY);
      a_last_q    <= last_i;
      a_edge_q    <= have_first_q;
      a_hit_q     <= (cur_x == '0) && (cur_y == '0);
      a_cur_x_q   <= cur_x;
      a_cur_y_q   <= cur_y;
      a_prev_x_q  <= prev_x_q;
      a_prev_y_q  <= prev_y_q;
      a_first_x_q <= first_x_sel;
      a_first_y_q <= first_y_sel;
    end
  end

  pipc_edge_term #(.DW(DW)) u_open_edge (
    .prev_x_i (a_prev_x_q),
    .prev_y_i (a_prev_y_q),
    .cur_x_i  (a_cur_x_q),
    .cur_y_i  (a_cur_y_q),
    .flags_o  (open_flags),
    .prod_a_o (open_pa),
    .prod_b_o (open_pb)
  );

  // closing edge runs from the current vertex back to the first one
  pipc_edge_term #(.DW(DW)) u_close_edge (
    .prev_x_i (a_cur_x_q),
    .prev_y_i (a_cur_y_q),
    .cur_x_i  (a_first_x_q),
    .cur_y_i  (a_first_y_q),
    .flags_o  (close_flags),
    .prod_a_o (close_pa),
    .prod_b_o (close_pb)
  );

  // stage B control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (a_move) begin
      b_valid_q <= 1'b1;
    end else if (b_fire) begin
      b_valid_q <= 1'b0;
    end
  end

  // stage B payload
  always_ff @(posedge clk_i) begin
    if (a_move) begin
      b_query_q       <= a_query_q;
      b_last_q        <= a_last_q;
      b_edge_q        <= a_edge_q;
      b_hit_q         <= a_hit_q;
      b_open_flags_q  <= open_flags;
      b_close_flags_q <= close_flags;
      b_open_pa_q     <= open_pa;
      b_open_pb_q     <= open_pb;
      b_close_pa_q    <= close_pa;
      b_close_pb_q    <= close_pb;
    end
  end

  always_comb begin
    open_tg  = pipc_pkg::edge_toggle(b_open_flags_q, b_open_pa_q > b_open_pb_q,
                                     b_open_pa_q == b_open_pb_q);
    close_tg = pipc_pkg::edge_toggle(b_close_flags_q, b_close_pa_q > b_close_pb_q,
                                     b_close_pa_q == b_close_pb_q);
    right_n  = right_q ^ (b_edge_q & open_tg.right) ^ (b_last_q & close_tg.right);
    left_n   = left_q ^ (b_edge_q & open_tg.left) ^ (b_last_q & close_tg.left);
    hit_n    = hit_q | b_hit_q;
  end

  // crossing parities; a query or a finished polygon starts them over
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      right_q <= 1'b0;
      left_q  <= 1'b0;
      hit_q   <= 1'b0;
    end else if (b_fire) begin
      if (b_query_q || b_last_q) begin
        right_q <= 1'b0;
        left_q  <= 1'b0;
        hit_q   <= 1'b0;
      end else begin
        right_q <= right_n;
        left_q  <= left_n;
        hit_q   <= hit_n;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (b_fire && b_result) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_fire && b_result) begin
      pos_q <= pipc_pkg::classify(hit_n, right_n, left_n);
    end
  end

  assign out_valid_o = out_valid_q;
  assign position_o  = pos_q;

endmodule

// ----- rtl/pipc_edge_term.sv -----
// Edge term of the crossing test: straddle flags and the two cross products
// of one edge, both taken relative to the query point. Uses pipc_pkg.
module pipc_edge_term #(
  parameter int DW = pipc_pkg::CoordWidth + 1
) (
  input  logic signed [DW-1:0]   prev_x_i,
  input  logic signed [DW-1:0]   prev_y_i,
  input  logic signed [DW-1:0]   cur_x_i,
  input  logic signed [DW-1:0]   cur_y_i,
  output pipc_pkg::edge_flags_t  flags_o,
  output logic signed [2*DW-1:0] prod_a_o,
  output logic signed [2*DW-1:0] prod_b_o
);

  always_comb begin
    flags_o.rs      = (cur_y_i > 0) != (prev_y_i > 0);
    flags_o.ls      = (cur_y_i < 0) != (prev_y_i < 0);
    flags_o.den_pos = prev_y_i > cur_y_i;
  end

  // numerator is cur_x*prev_y - prev_x*cur_y; only its sign is needed later
  assign prod_a_o = cur_x_i * prev_y_i;
  assign prod_b_o = prev_x_i * cur_y_i;

endmodule

// ----- rtl/pipc_checker.sv -----
// Port-level checks for point_in_polygon_classifier_unit, bound to the top.
// Depends on pipc_pkg for the port widths.
module pipc_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_stall_o,
  input logic                             op_i,
  input logic [pipc_pkg::CoordFieldW-1:0] coord_x_i,
  input logic [pipc_pkg::CoordFieldW-1:0] coord_y_i,
  input logic                             last_i,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic [1:0]                       position_o
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(position_o))
    else $error("result dropped or changed while stalled");

  // a stalled request stays put
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=>
      in_valid_i && $stable({op_i, coord_x_i, coord_y_i, last_i}))
    else $error("request dropped or changed while stalled");

  // input side backs up only behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled result");

  // no result is present right after reset
  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o ##1 !out_valid_o)
    else $error("result present right after reset");

endmodule

bind point_in_polygon_classifier_unit pipc_checker u_pipc_checker (.*);

// ----- tb/sv/pipc_position_checker.sv -----
`timescale 1ns / 100ps
// Position checker for point_in_polygon_classifier_unit: watches both channels,
// predicts each polygon's position with its own crossing-parity model, compares.
// Depends on pipc_pkg for the op and position codes and the port widths.
module pipc_position_checker #(
  parameter int COORD_WIDTH = pipc_pkg::CoordWidth
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_stall_i,
  input  logic                             op_i,
  input  logic [pipc_pkg::CoordFieldW-1:0] coord_x_i,
  input  logic [pipc_pkg::CoordFieldW-1:0] coord_y_i,
  input  logic                             last_i,
  input  logic                             out_valid_i,
  input  logic                             out_stall_i,
  input  logic [1:0]                       position_i,
  output int                               mismatches_o,
  output int                               pending_o
);

  localparam int MaxReports = 10;
  localparam int FW         = pipc_pkg::CoordFieldW;

  // Vertex offsets from the point need one extra bit.
  typedef logic signed [FW:0] offset_t;

  logic signed [FW-1:0] point_x, point_y;
  offset_t              first_dx, first_dy, prev_dx, prev_dy;
  logic                 have_first, right_par, left_par, hit;
  pipc_pkg::position_e  expected_positions[$];

  function automatic logic signed [FW-1:0] widen(logic [FW-1:0] raw);
    logic signed [FW-1:0] t;
    t = raw << (FW - COORD_WIDTH);
    return t >>> (FW - COORD_WIDTH);
  endfunction

  // Sign of a*b - c*d, computed wide enough to be exact.
  function automatic int cross_sign(offset_t a, offset_t b, offset_t c, offset_t d);
    logic signed [2*FW+3:0] diff;
    diff = a * b - c * d;
    return (diff > 0) ? 1 : ((diff < 0) ? -1 : 0);
  endfunction

  task automatic cross_edge(input offset_t xp, input offset_t yp,
                            input offset_t xc, input offset_t yc);
    logic rs, ls, den_pos;
    int   num;
    rs = (yc > 0) != (yp > 0);
    ls = (yc < 0) != (yp < 0);
    if (rs || ls) begin
      num     = cross_sign(xc, yp, xp, yc);
      den_pos = yp > yc;
      if (rs && num != 0 && ((num > 0) == den_pos)) right_par = !right_par;
      if (ls && num != 0 && ((num > 0) != den_pos)) left_par = !left_par;
    end
  endtask

  task automatic clear_polygon();
    first_dx   = '0;
    first_dy   = '0;
    prev_dx    = '0;
    prev_dy    = '0;
    have_first = 1'b0;
    right_par  = 1'b0;
    left_par   = 1'b0;
    hit        = 1'b0;
  endtask

  task automatic take_request(input logic op, input logic [FW-1:0] x,
                              input logic [FW-1:0] y, input logic lst);
    logic signed [FW-1:0] cx, cy;
    offset_t              dx, dy;
    pipc_pkg::position_e  pos;
    cx = widen(x);
    cy = widen(y);
    if (op == pipc_pkg::OP_QUERY) begin
      point_x = cx;
      point_y = cy;
      clear_polygon();
    end else begin
      dx = offset_t'(cx) - offset_t'(point_x);
      dy = offset_t'(cy) - offset_t'(point_y);
      if (dx == 0 && dy == 0) hit = 1'b1;
      if (!have_first) begin
        first_dx   = dx;
        first_dy   = dy;
        have_first = 1'b1;
      end else begin
        cross_edge(prev_dx, prev_dy, dx, dy);
      end
      prev_dx = dx;
      prev_dy = dy;
      if (lst) begin
        // closing edge back to the first vertex
        cross_edge(dx, dy, first_dx, first_dy);
        if (hit) pos = pipc_pkg::POS_VERTEX;
        else if (right_par != left_par) pos = pipc_pkg::POS_ON_EDGE;
        else if (right_par) pos = pipc_pkg::POS_INTERIOR;
        else pos = pipc_pkg::POS_EXTERIOR;
        expected_positions.push_back(pos);
        clear_polygon();
      end
    end
  endtask

  task automatic check_position(input logic [1:0] got);
    pipc_pkg::position_e want;
    if (expected_positions.size() == 0) begin
      if (mismatches_o < MaxReports) $display("%0t: unexpected position %0d", $realtime, got);
      mismatches_o++;
    end else begin
      want = expected_positions.pop_front();
      if (got !== want) begin
        if (mismatches_o < MaxReports) begin
          $display("%0t: position mismatch, expected %0d actual %0d", $realtime, want, got);
        end
        mismatches_o++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_x = '0;
      point_y = '0;
      clear_polygon();
      expected_positions.delete();
      mismatches_o = 0;
      pending_o    = 0;
    end else begin
      // a result always appears after its request is taken, so order here is free
      if (out_valid_i && !out_stall_i) check_position(position_i);
      if (in_valid_i && !in_stall_i) take_request(op_i, coord_x_i, coord_y_i, last_i);
      pending_o = expected_positions.size();
    end
  end

endmodule

// ----- tb/sv/point_in_polygon_classifier_unit_tb.sv -----
`timescale 1ns / 100ps
// Testbench top for point_in_polygon_classifier_unit: clock, reset, request and
// stall stimulus, verdict. Depends on pipc_pkg and pipc_position_checker.
module point_in_polygon_classifier_unit_tb;

  localparam int CycleLimit   = 200000;
  localparam int DrainCycles  = 12;
  localparam int RandomItems  = 1630;
  localparam int IdlePercent  = 18;
  localparam int FW           = pipc_pkg::CoordFieldW;

  logic          clk;
  logic          rst_n     = 1'b0;
  logic          in_valid  = 1'b0;
  logic          in_stall;
  logic          op        = pipc_pkg::OP_QUERY;
  logic [FW-1:0] coord_x   = '0;
  logic [FW-1:0] coord_y   = '0;
  logic          last      = 1'b0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [1:0]    position;
  logic          calm      = 1'b0;  // no idling on either side while set
  int            mismatches, pending;
  int            cycle_count = 0;

  point_in_polygon_classifier_unit u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .op_i        (op),
    .coord_x_i   (coord_x),
    .coord_y_i   (coord_y),
    .last_i      (last),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .position_o  (position)
  );

  pipc_position_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .op_i         (op),
    .coord_x_i    (coord_x),
    .coord_y_i    (coord_y),
    .last_i       (last),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .position_i   (position),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < IdlePercent);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [FW-1:0] q16(int v);
    return v <<< 16;
  endfunction

  // Stall is sampled at the falling edge; nothing changes before the next rise.
  task automatic send_req(input pipc_pkg::op_e kind, input logic [FW-1:0] x,
                          input logic [FW-1:0] y, input logic lst);
    logic stalled;
    while (!calm && $urandom_range(99) < IdlePercent) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= kind;
    coord_x  <= x;
    coord_y  <= y;
    last     <= lst;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
  endtask

  task automatic run_directed();
    // vertices before any query use the reset point at the origin
    send_req(pipc_pkg::OP_VERTEX, q16(-1), q16(-1), 1'b0);
    send_req(pipc_pkg::OP_VERTEX, q16(1),  q16(-1), 1'b0);
    send_req(pipc_pkg::OP_VERTEX, q16(1),  q16(1),  1'b0);
    send_req(pipc_pkg::OP_VERTEX, q16(-1), q16(1),  1'b1);
    // extreme point, single vertex polygon at the opposite extreme
    send_req(pipc_pkg::OP_QUERY,  32'h7fff_ffff, 32'h8000_0000, 1'b0);
    send_req(pipc_pkg::OP_VERTEX, 32'h8000_0000, 32'h7fff_ffff, 1'b1);
    // last on a query is ignored
    send_req(pipc_pkg::OP_QUERY,  '0, '0, 1'b1);
    // point is a vertex
    send_req(pipc_pkg::OP_VERTEX, '0, '0, 1'b0);
    send_req(pipc_pkg::OP_VERTEX, q16(5), '0, 1'b0);
    send_req(pipc_pkg::OP_VERTEX, '0, q16(5), 1'b1);
    // point on the right edge of a square
    send_req(pipc_pkg::OP_QUERY,  q16(2),  '0,      1'b0);
    send_req(pipc_pkg::OP_VERTEX, q16(-2), q16(-2), 1'b0);
    send_req(pipc_pkg::OP_VERTEX, q16(2),  q16(-2), 1'b0);
    send_req(pipc_pkg::OP_VERTEX, q16(2),  q16(2),  1'b0);
    send_req(pipc_pkg::OP_VERTEX, q16(-2), q16(2),  1'b1);
    // query with no vertices, then a full-range triangle around the origin
    send_req(pipc_pkg::OP_QUERY,  q16(1), q16(1), 1'b0);
    send_req(pipc_pkg::OP_QUERY,  '0, '0, 1'b0);
    send_req(pipc_pkg::OP_VERTEX, 32'h8000_0000, 32'h8000_0000, 1'b0);
    send_req(pipc_pkg::OP_VERTEX, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
    send_req(pipc_pkg::OP_VERTEX, 32'hffff_ffff, 32'h7fff_ffff, 1'b1);
  endtask

  // Grid coordinates near the point make hits, edge cases and flat edges common.
  function automatic logic [FW-1:0] pick_coord(int mode, int base, int scale);
    logic [FW-1:0] corners[5];
    corners = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h1};
    case (mode)
      0:       return base + ($urandom_range(6) - 3) * scale;
      1:       return $urandom();
      default: return corners[$urandom_range(4)];
    endcase
  endfunction

  task automatic run_random(input int target);
    int sent, nverts, mode, scale, px, py, r;
    sent = 0;
    px   = 0;
    py   = 0;
    while (sent < target) begin
      calm <= (sent > target / 3) && (sent < target / 2);
      r = $urandom_range(99);
      if (r < 8) begin
        // noise: empty query, sometimes flagged last
        send_req(pipc_pkg::OP_QUERY, $urandom(), $urandom(), 1'($urandom_range(1)));
        sent++;
      end else begin
        case ($urandom_range(2))
          0:       scale = 1;
          1:       scale = 1 << 8;
          default: scale = 1 << 16;
        endcase
        if (r >= 20) begin
          if ($urandom_range(9) < 7) begin
            px = ($urandom_range(8) - 4) * scale;
            py = ($urandom_range(8) - 4) * scale;
          end else begin
            px = $urandom();
            py = $urandom();
          end
          send_req(pipc_pkg::OP_QUERY, px, py, 1'b0);
          sent++;
        end
        r    = $urandom_range(99);
        mode = (r < 70) ? 0 : ((r < 92) ? 1 : 2);
        nverts = ($urandom_range(9) == 0) ? $urandom_range(16, 9) : $urandom_range(8, 1);
        for (int i = 0; i < nverts; i++) begin
          // a few polygons are cut short and left for the next query to drop
          if (i == nverts - 1 && $urandom_range(19) == 0) break;
          send_req(pipc_pkg::OP_VERTEX, pick_coord(mode, px, scale),
                   pick_coord(mode, py, scale), i == nverts - 1);
          sent++;
        end
      end
    end
    calm <= 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_random(RandomItems);
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/pipc_pkg.sv
rtl/pipc_edge_term.sv
rtl/point_in_polygon_classifier_unit.sv
rtl/pipc_checker.sv
tb/sv/pipc_position_checker.sv
tb/sv/point_in_polygon_classifier_unit_tb.sv
